// ----- rtl/core/fpsch_pkg.sv -----
// Package for the frame pacing scheduler: field widths, timing constants,
// sequencer states and the request/response types of the shared add/sub unit.
// Depends on nothing.
`timescale 1ns / 1ps

package fpsch_pkg;

	localparam int TS_W   = 64;
	localparam int AVG_W  = 28;
	localparam int FPS_W  = 17;
	localparam int CNT_W  = 32;
	localparam int HZ_W   = 8;
	localparam int IVL_W  = 27;

	localparam int DVD_W   = 38;
	localparam int REM_W   = 28;
	localparam int ITER_W  = 6;
	localparam int SHORT_N = 31;
	localparam int LONG_N  = 38;

	localparam logic [ITER_W-1:0] SHORT_LAST = ITER_W'(SHORT_N - 1);
	localparam logic [ITER_W-1:0] LONG_LAST  = ITER_W'(LONG_N - 1);

	localparam logic [HZ_W-1:0] HZ_MIN   = 8'd30;
	localparam logic [HZ_W-1:0] HZ_MAX   = 8'd240;
	localparam logic [HZ_W-1:0] HZ_RESET = 8'd60;

	localparam logic [AVG_W-1:0] AVG_RESET = 28'd33333333;
	localparam logic [AVG_W-1:0] AVG_120   = 28'd8333334;
	localparam logic [AVG_W-1:0] AVG_15    = 28'd66666666;
	localparam logic [AVG_W-1:0] AVG_LOW   = 28'd2000000;
	localparam logic [AVG_W-1:0] AVG_HIGH  = 28'd250000000;
	localparam logic [FPS_W-1:0] FPS_RESET = 17'd7680;

	localparam logic [TS_W-1:0] GAP_MIN = 64'd2000000;
	localparam logic [TS_W-1:0] GAP_MAX = 64'd250000000;

	localparam logic [DVD_W-1:0] IVL_DVD = DVD_W'(64'd2000000000 << (DVD_W - SHORT_N));
	localparam logic [DVD_W-1:0] FPS_DVD = 38'd256000000000;

	// floor(x / 5) equals (x * EMA_RECIP) >> EMA_SHIFT for every x below 2^34.
	localparam logic [31:0] EMA_RECIP = 32'hCCCCCCCD;
	localparam int          EMA_SHIFT = 34;

	localparam logic ACTION_SCHED   = 1'b0;
	localparam logic ACTION_PRESENT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_IVL_DIV,
		ST_SCHED_CMP,
		ST_SCHED_ADD,
		ST_GAP,
		ST_AVG_SUM,
		ST_AVG_DIV,
		ST_FPS_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [TS_W-1:0] a;
		logic [TS_W-1:0] b;
		logic            sub;
	} alu_req_t;

	typedef struct packed {
		logic [TS_W-1:0] sum;
		logic            carry;
	} alu_rsp_t;

endpackage

// ----- rtl/core/fpsch_if.sv -----
// Valid/ready channel interfaces for the schedule and present requests and
// for the result items. Depends on fpsch_pkg.
`timescale 1ns / 1ps

interface fpsch_in_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [fpsch_pkg::TS_W-1:0] timestamp_ns;

	modport source (output valid, action, timestamp_ns, input ready);
	modport sink (input valid, action, timestamp_ns, output ready);
endinterface

interface fpsch_out_if;
	logic                        valid;
	logic                        ready;
	logic [fpsch_pkg::TS_W-1:0]  present_at_ns;
	logic [fpsch_pkg::AVG_W-1:0] avg_frame_ns;
	logic [fpsch_pkg::FPS_W-1:0] base_fps_q8;
	logic                        make_intermediate;
	logic [fpsch_pkg::CNT_W-1:0] frames_presented;

	modport source (output valid, present_at_ns, avg_frame_ns, base_fps_q8,
		make_intermediate, frames_presented, input ready);
	modport sink (input valid, present_at_ns, avg_frame_ns, base_fps_q8,
		make_intermediate, frames_presented, output ready);
endinterface

// ----- rtl/core/fpsch_addsub.sv -----
// Shared 64-bit adder/subtractor used by the division, compare, add, gap and sum steps of the sequencer.
// Depends on fpsch_pkg for the request and response types.
`timescale 1ns / 1ps

module fpsch_addsub (
	input  fpsch_pkg::alu_req_t req,
	output fpsch_pkg::alu_rsp_t rsp
);
	import fpsch_pkg::*;

	logic [TS_W:0] full;

	always_comb begin
		full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{TS_W{1'b0}}, req.sub};
		rsp.sum = full[TS_W-1:0];
		rsp.carry = full[TS_W];
	end

endmodule

// ----- rtl/core/frame_pacing_scheduler.sv -----
// Frame pacing scheduler top level: sequencer, state registers and output register.
// Depends on fpsch_pkg, fpsch_if and fpsch_addsub.
// A schedule request is worked by a 31-step restoring division of 2e9 by target_hz
// on the shared add/sub unit. A present request takes one multiply by the reciprocal
// of five for the average and 38 division steps for the rate, or skips both when
// the measured gap lies outside 2 to 250 ms. One request is in work at a time; the
// next one is taken the cycle after a result is registered, even while that result
// still waits to be taken.
`timescale 1ns / 1ps

module frame_pacing_scheduler (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fpsch_pkg::HZ_W-1:0] cfg_wdata,
	fpsch_in_if.sink                   item,
	fpsch_out_if.source                result
);
	import fpsch_pkg::*;

	state_t state_q, state_d;

	logic              armed_q;
	logic [TS_W-1:0]   deadline_q;
	logic [TS_W-1:0]   last_q;
	logic [AVG_W-1:0]  avg_q;
	logic [FPS_W-1:0]  fps_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HZ_W-1:0]   hz_q;
	logic              out_valid_q;

	logic              action_q;
	logic [TS_W-1:0]   now_q;
	logic [IVL_W-1:0]  ivl_q;
	logic              rebase_q;
	logic [TS_W-1:0]   gap_q;
	logic [TS_W-1:0]   present_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dvsr_q;
	logic [ITER_W-1:0] iter_q;

	logic [TS_W-1:0]   out_present_q;
	logic [AVG_W-1:0]  out_avg_q;
	logic [FPS_W-1:0]  out_fps_q;
	logic              out_inter_q;
	logic [CNT_W-1:0]  out_cnt_q;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [REM_W:0]    shifted;
	logic [REM_W-1:0]  rem_next;
	logic [DVD_W-1:0]  dvd_next;
	logic [TS_W-1:0]   ema_prod;
	logic [AVG_W-1:0]  ema_avg;
	logic              accept;
	logic              out_load;
	logic              gap_ok;
	logic              cfg_take;

	fpsch_addsub u_addsub (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_comb begin
		shifted  = {rem_q, dvd_q[DVD_W-1]};
		rem_next = alu_rsp.carry ? alu_rsp.sum[REM_W-1:0] : shifted[REM_W-1:0];
		dvd_next = {dvd_q[DVD_W-2:0], alu_rsp.carry};
		ema_prod = TS_W'(dvd_q[SHORT_N-1:0]) * TS_W'(EMA_RECIP);
		ema_avg  = ema_prod[EMA_SHIFT +: AVG_W];
		gap_ok   = (gap_q >= GAP_MIN) && (gap_q <= GAP_MAX);
		cfg_take = cfg_we && (cfg_wdata >= HZ_MIN) && (cfg_wdata <= HZ_MAX) && (cfg_wdata != hz_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					state_d = (item.action == ACTION_PRESENT) ? ST_GAP : ST_IVL_DIV;
				end
			end
			ST_IVL_DIV: begin
				if (iter_q == '0) begin
					state_d = ST_SCHED_CMP;
				end
			end
			ST_SCHED_CMP: state_d = ST_SCHED_ADD;
			ST_SCHED_ADD: state_d = ST_OUT;
			ST_GAP:       state_d = ST_AVG_SUM;
			ST_AVG_SUM:   state_d = gap_ok ? ST_AVG_DIV : ST_OUT;
			ST_AVG_DIV:   state_d = ST_FPS_DIV;
			ST_FPS_DIV: begin
				if (iter_q == '0) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready  = 1'b0;
		out_load    = 1'b0;
		alu_req.a   = TS_W'(shifted);
		alu_req.b   = TS_W'(dvsr_q);
		alu_req.sub = 1'b1;
		unique case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_SCHED_CMP: begin
				alu_req.a = now_q;
				alu_req.b = deadline_q;
			end
			ST_SCHED_ADD: begin
				alu_req.a   = rebase_q ? now_q : deadline_q;
				alu_req.b   = TS_W'(ivl_q);
				alu_req.sub = 1'b0;
			end
			ST_GAP: begin
				alu_req.a = now_q;
				alu_req.b = last_q;
			end
			ST_AVG_SUM: begin
				alu_req.a   = TS_W'({avg_q, 2'b00});
				alu_req.b   = gap_q;
				alu_req.sub = 1'b0;
			end
			ST_OUT: out_load = !out_valid_q || result.ready;
			default: begin
			end
		endcase
	end

	assign accept = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			armed_q     <= 1'b0;
			deadline_q  <= '0;
			last_q      <= '0;
			avg_q       <= AVG_RESET;
			fps_q       <= FPS_RESET;
			cnt_q       <= '0;
			hz_q        <= HZ_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_SCHED_ADD: begin
					deadline_q <= alu_rsp.sum;
					armed_q    <= 1'b1;
				end
				ST_GAP: begin
					last_q <= now_q;
					cnt_q  <= cnt_q + 1'b1;
				end
				ST_AVG_DIV: avg_q <= ema_avg;
				ST_FPS_DIV: begin
					if (iter_q == '0) begin
						fps_q <= dvd_next[FPS_W-1:0];
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_take) begin
				hz_q    <= cfg_wdata;
				armed_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= item.action;
			now_q    <= item.timestamp_ns;
			dvd_q    <= IVL_DVD;
			rem_q    <= '0;
			dvsr_q   <= REM_W'(hz_q);
			iter_q   <= SHORT_LAST;
		end
		case (state_q)
			ST_IVL_DIV, ST_FPS_DIV: begin
				dvd_q  <= dvd_next;
				rem_q  <= rem_next;
				iter_q <= iter_q - 1'b1;
				if (state_q == ST_IVL_DIV && iter_q == '0) begin
					ivl_q <= dvd_next[IVL_W-1:0];
				end
			end
			ST_SCHED_CMP: rebase_q <= !armed_q || alu_rsp.carry;
			ST_SCHED_ADD: present_q <= rebase_q ? now_q : deadline_q;
			ST_GAP: begin
				gap_q     <= alu_rsp.sum;
				present_q <= now_q;
			end
			ST_AVG_SUM: dvd_q <= DVD_W'(alu_rsp.sum[SHORT_N-1:0]);
			ST_AVG_DIV: begin
				dvd_q  <= FPS_DVD;
				rem_q  <= '0;
				dvsr_q <= ema_avg;
				iter_q <= LONG_LAST;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_present_q <= (action_q == ACTION_PRESENT) ? now_q : present_q;
			out_avg_q     <= avg_q;
			out_fps_q     <= fps_q;
			out_inter_q   <= (avg_q >= AVG_120) && (avg_q <= AVG_15);
			out_cnt_q     <= cnt_q;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.present_at_ns     = out_present_q;
	assign result.avg_frame_ns      = out_avg_q;
	assign result.base_fps_q8       = out_fps_q;
	assign result.make_intermediate = out_inter_q;
	assign result.frames_presented  = out_cnt_q;

endmodule

// ----- rtl/core/fpsch_checker.sv -----
// Port-level checker for the frame pacing scheduler and its bind statement.
// Depends on fpsch_pkg and the frame_pacing_scheduler top level.
`timescale 1ns / 1ps

module fpsch_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [fpsch_pkg::TS_W-1:0]  present_at_ns,
	input logic [fpsch_pkg::AVG_W-1:0] avg_frame_ns,
	input logic                        make_intermediate
);
	import fpsch_pkg::*;

	logic [1:0] open_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (in_acc && !out_acc) begin
			open_q <= open_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			open_q <= open_q - 1'b1;
		end
	end

	// A result waiting on a stalled sink keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(present_at_ns) && $stable(avg_frame_ns))
		else $error("result changed while stalled");

	// Only one request is worked on at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request taken while busy");

	// At most one request in work plus one result waiting, and no result without a request.
	a_outstanding: assert property (@(posedge clk) disable iff (!arst_n)
		(open_q != 2'd3) && (!out_valid || open_q != 2'd0))
		else $error("result count out of step with requests");

	// The intermediate-frame flag follows the reported average, which stays within 2 to 250 ms.
	a_intermediate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (make_intermediate == ((avg_frame_ns >= AVG_120) && (avg_frame_ns <= AVG_15)))
			&& (avg_frame_ns >= AVG_LOW) && (avg_frame_ns <= AVG_HIGH))
		else $error("average or intermediate flag inconsistent");

endmodule

bind frame_pacing_scheduler fpsch_checker u_fpsch_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (item.valid),
	.in_ready          (item.ready),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.present_at_ns     (result.present_at_ns),
	.avg_frame_ns      (result.avg_frame_ns),
	.make_intermediate (result.make_intermediate)
);

// ----- test/frame_pacing_scheduler_test.sv -----
// Self-checking testbench for the frame pacing scheduler: directed deadline, statistics and
// rate cases, a long result stall, then randomized frame traffic checked against a predictor.
// Depends on fpsch_pkg, fpsch_if and the frame_pacing_scheduler RTL.
`timescale 1ns / 1ps

module frame_pacing_scheduler_test;
	import fpsch_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned STALL_CYCLES = 400;
	localparam logic [TS_W-1:0] TWO_SECONDS_NS = 64'd2000000000;
	localparam logic [TS_W-1:0] MIN_GAP_NS = 64'd2000000;
	localparam logic [TS_W-1:0] MAX_GAP_NS = 64'd250000000;
	localparam logic [TS_W-1:0] Q8_RATE_SCALE = 64'd256000000000;
	localparam logic [AVG_W-1:0] AVG_AT_120FPS = 28'd8333334;
	localparam logic [AVG_W-1:0] AVG_AT_15FPS = 28'd66666666;
	localparam logic [HZ_W-1:0] LOWEST_HZ = 8'd30;
	localparam logic [HZ_W-1:0] HIGHEST_HZ = 8'd240;
	localparam logic [HZ_W-1:0] DEFAULT_HZ = 8'd60;

	typedef struct packed {
		logic [TS_W-1:0]  present_at_ns;
		logic [AVG_W-1:0] avg_frame_ns;
		logic [FPS_W-1:0] base_fps_q8;
		logic             make_intermediate;
		logic [CNT_W-1:0] frames_presented;
	} pacing_result_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [HZ_W-1:0] cfg_wdata;

	fpsch_in_if  item_ch();
	fpsch_out_if result_ch();

	frame_pacing_scheduler i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item_ch),
		.result   (result_ch)
	);

	logic [HZ_W-1:0]  rate_hz;
	logic             deadline_armed;
	logic [TS_W-1:0]  deadline_ns;
	logic [TS_W-1:0]  last_present_ns;
	logic [AVG_W-1:0] avg_ns;
	logic [FPS_W-1:0] fps_q8;
	logic [CNT_W-1:0] present_total;
	logic [IVL_W-1:0] interval_ns;

	pacing_result_t  pending_results[$];
	int unsigned     error_count = 0;
	int unsigned     cycle_count = 0;
	int unsigned     requests_sent = 0;
	int unsigned     src_idle_pct = 0;
	int unsigned     sink_idle_pct = 0;
	int unsigned     hold_off_left = 0;
	logic            stall_req = 1'b0;
	logic            stall_seen = 1'b0;
	int unsigned     pace_regime = 1;
	logic [TS_W-1:0] sim_now = 64'd0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [IVL_W-1:0] interval_for_rate(logic [HZ_W-1:0] hz);
		return IVL_W'(TWO_SECONDS_NS / TS_W'(hz));
	endfunction

	function automatic void reset_pacing_state();
		rate_hz = DEFAULT_HZ;
		deadline_armed = 1'b0;
		deadline_ns = '0;
		last_present_ns = '0;
		avg_ns = 28'd33333333;
		fps_q8 = 17'd7680;
		present_total = '0;
		interval_ns = interval_for_rate(DEFAULT_HZ);
	endfunction

	function automatic void apply_rate_write(logic [HZ_W-1:0] hz);
		if (hz < LOWEST_HZ || hz > HIGHEST_HZ || hz == rate_hz)
			return;
		rate_hz = hz;
		interval_ns = interval_for_rate(hz);
		deadline_armed = 1'b0;
	endfunction

	function automatic pacing_result_t advance_pacing(logic act, logic [TS_W-1:0] now);
		pacing_result_t  r;
		logic [TS_W-1:0] gap;
		r.present_at_ns = now;
		if (act == ACTION_SCHED) begin
			if (!deadline_armed || now >= deadline_ns) begin
				deadline_ns = now + TS_W'(interval_ns);
				deadline_armed = 1'b1;
			end else begin
				r.present_at_ns = deadline_ns;
				deadline_ns = deadline_ns + TS_W'(interval_ns);
			end
		end else begin
			gap = now - last_present_ns;
			last_present_ns = now;
			if (gap >= MIN_GAP_NS && gap <= MAX_GAP_NS) begin
				avg_ns = AVG_W'((64'd4 * TS_W'(avg_ns) + gap) / 64'd5);
				fps_q8 = FPS_W'(Q8_RATE_SCALE / TS_W'(avg_ns));
			end
			present_total = present_total + 1'b1;
		end
		r.avg_frame_ns = avg_ns;
		r.base_fps_q8 = fps_q8;
		r.make_intermediate = (avg_ns >= AVG_AT_120FPS) && (avg_ns <= AVG_AT_15FPS);
		r.frames_presented = present_total;
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input logic [TS_W-1:0] got,
		input logic [TS_W-1:0] want);
		$display("mismatch in %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $time);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (stall_req != stall_seen) begin
			stall_seen <= stall_req;
			result_ch.ready <= 1'b0;
			hold_off_left <= STALL_CYCLES;
		end else if (hold_off_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_off_left <= hold_off_left - 1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		pacing_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with no request pending", result_ch.present_at_ns, '0);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.present_at_ns !== want.present_at_ns)
					flag_mismatch("present_at_ns", result_ch.present_at_ns, want.present_at_ns);
				if (result_ch.avg_frame_ns !== want.avg_frame_ns)
					flag_mismatch("avg_frame_ns", result_ch.avg_frame_ns, want.avg_frame_ns);
				if (result_ch.base_fps_q8 !== want.base_fps_q8)
					flag_mismatch("base_fps_q8", result_ch.base_fps_q8, want.base_fps_q8);
				if (result_ch.make_intermediate !== want.make_intermediate)
					flag_mismatch("make_intermediate", result_ch.make_intermediate,
						want.make_intermediate);
				if (result_ch.frames_presented !== want.frames_presented)
					flag_mismatch("frames_presented", result_ch.frames_presented,
						want.frames_presented);
			end
		end
	end

	task automatic send_request(input logic act, input logic [TS_W-1:0] ts);
		int unsigned gap_cycles;
		gap_cycles = 0;
		while ($urandom_range(99) < src_idle_pct)
			gap_cycles++;
		if (gap_cycles > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap_cycles) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.timestamp_ns <= ts;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		pending_results.push_back(advance_pacing(act, ts));
		requests_sent++;
	endtask

	task automatic wait_until_idle();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_target_rate(input logic [HZ_W-1:0] hz);
		wait_until_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= hz;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_rate_write(hz);
	endtask

	function automatic logic [TS_W-1:0] pick_frame_gap();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return TS_W'($urandom_range(1999999));
		if (pick < 10)
			return TS_W'($urandom_range(400000000, 250000001));
		case (pace_regime)
			0: return TS_W'($urandom_range(9000000, 2000000));
			1: return TS_W'($urandom_range(67000000, 8000000));
			2: return TS_W'($urandom_range(250000000, 60000000));
			default: begin
				case ($urandom_range(3))
					0: return 64'd1999999;
					1: return MIN_GAP_NS;
					2: return MAX_GAP_NS;
					default: return 64'd250000001;
				endcase
			end
		endcase
	endfunction

	function automatic logic [HZ_W-1:0] pick_rate();
		case ($urandom_range(9))
			0: return rate_hz;
			1: return LOWEST_HZ;
			2: return HIGHEST_HZ;
			3: return $urandom_range(1) ? HZ_W'($urandom_range(29)) : HZ_W'($urandom_range(255, 241));
			default: return HZ_W'($urandom_range(240, 30));
		endcase
	endfunction

	// One game-loop frame: a schedule request somewhere inside the frame, sometimes a second
	// one, then the present request exactly one frame gap after the start of the frame.
	task automatic send_frame();
		logic [TS_W-1:0] gap;
		gap = pick_frame_gap();
		send_request(ACTION_SCHED, sim_now + $urandom_range(32'(gap)));
		if ($urandom_range(99) < 15)
			send_request(ACTION_SCHED, sim_now + $urandom_range(32'(gap)));
		sim_now = sim_now + gap;
		send_request(ACTION_PRESENT, sim_now);
	endtask

	task automatic send_noise();
		logic [TS_W-1:0] ts;
		case ($urandom_range(2))
			0: begin
				ts = {$urandom, $urandom};
				if ($urandom_range(1))
					sim_now = ts;
			end
			1: ts = sim_now - $urandom_range(100000000, 1);
			default: ts = sim_now;
		endcase
		send_request(logic'($urandom_range(1)), ts);
	endtask

	task automatic test_schedule_deadlines();
		send_request(ACTION_SCHED, 64'd1000);
		send_request(ACTION_SCHED, 64'd2000);
		send_request(ACTION_SCHED, deadline_ns);
		send_request(ACTION_SCHED, deadline_ns + 64'd5000000);
		// The deadline wraps past the top of the time range here.
		send_request(ACTION_SCHED, {TS_W{1'b1}});
		send_request(ACTION_SCHED, 64'd0);
		send_request(ACTION_SCHED, 64'd0);
	endtask

	task automatic test_present_statistics();
		send_request(ACTION_PRESENT, 64'd0);
		send_request(ACTION_PRESENT, 64'd2000000);
		send_request(ACTION_PRESENT, 64'd3999999);
		send_request(ACTION_PRESENT, 64'd253999999);
		send_request(ACTION_PRESENT, 64'd504000000);
		send_request(ACTION_PRESENT, 64'd503999990);
		send_request(ACTION_PRESENT, {TS_W{1'b1}});
		send_request(ACTION_PRESENT, 64'd0);
	endtask

	task automatic test_rate_register();
		write_target_rate(LOWEST_HZ);
		send_request(ACTION_SCHED, 64'd1000000000);
		send_request(ACTION_SCHED, 64'd1000000001);
		write_target_rate(HIGHEST_HZ);
		send_request(ACTION_SCHED, 64'd1000000002);
		send_request(ACTION_SCHED, 64'd1000000003);
		write_target_rate(HIGHEST_HZ);
		send_request(ACTION_SCHED, 64'd1000000004);
		write_target_rate(8'd29);
		write_target_rate(8'd241);
		write_target_rate(8'd0);
		write_target_rate(8'd255);
		send_request(ACTION_SCHED, 64'd1000000005);
		write_target_rate(DEFAULT_HZ);
		wait_until_idle();
	endtask

	task automatic test_result_backpressure();
		src_idle_pct = 0;
		stall_req <= !stall_req;
		repeat (6) send_frame();
		wait_until_idle();
	endtask

	task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
		input int unsigned n_requests);
		int unsigned first;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		first = requests_sent;
		while (requests_sent - first < n_requests) begin
			if ($urandom_range(99) < 3)
				write_target_rate(pick_rate());
			if ($urandom_range(99) < 5)
				pace_regime = $urandom_range(3);
			if ($urandom_range(99) < 85)
				send_frame();
			else
				send_noise();
		end
		wait_until_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.action <= ACTION_SCHED;
		item_ch.timestamp_ns <= '0;
		reset_pacing_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 34;
		sink_idle_pct = 62;
		test_schedule_deadlines();
		test_present_statistics();
		test_rate_register();
		test_result_backpressure();

		sim_now = 64'd1000000000000;
		test_random_traffic(34, 62, 260);
		test_random_traffic(62, 34, 260);
		test_random_traffic(0, 0, 260);

		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
